### hw/rtl/sscs_pkg.sv
package sscs_pkg;

  // Default sizing of the store
  localparam int DEF_MAX_ENTITIES = 128;
  localparam int DEF_MAX_SLOTS    = 128;
  localparam int DEF_NUM_TYPES    = 8;
  localparam int DEF_RECORD_BITS  = 64;

  // Fixed port widths
  localparam int OP_W       = 2;
  localparam int TYPE_W     = 3;
  localparam int ENT_W      = 7;
  localparam int SLOT_OUT_W = 7;
  localparam int PAYLOAD_W  = 64;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 8;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STS_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] STS_ABSENT = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // clear sweep step over the sparse table
    logic accept;  // input beat taken, latch fields
    logic dread;   // sparse entry back, issue dense read
    logic exec;    // dense entry back, do writes, form result
    logic fix;     // repoint moved entity in sparse table
    logic load;    // move result into output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic need_fix;
    logic out_free;
  } ctrl_sts_t;

endpackage

### hw/rtl/sscs_ram.sv
module sscs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/sscs_ctrl.sv
module sscs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output sscs_pkg::ctrl_cmd_t   cmd_o,
  input  sscs_pkg::ctrl_sts_t   sts_i
);
  import sscs_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DREAD = 6'b000100,
    ST_EXEC  = 6'b001000,
    ST_FIX   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sts_i.clr_done) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_DREAD;
      ST_DREAD: state_d = ST_EXEC;
      ST_EXEC:  state_d = sts_i.need_fix ? ST_FIX : ST_DONE;
      ST_FIX:   state_d = ST_DONE;
      ST_DONE:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands
  assign in_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.clear  = (state_q == ST_CLEAR);
  assign cmd_o.accept = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.dread  = (state_q == ST_DREAD);
  assign cmd_o.exec   = (state_q == ST_EXEC);
  assign cmd_o.fix    = (state_q == ST_FIX);
  assign cmd_o.load   = (state_q == ST_DONE) && sts_i.out_free;

endmodule

### hw/rtl/sscs_datapath.sv
module sscs_datapath #(
  parameter int MAX_ENTITIES = sscs_pkg::DEF_MAX_ENTITIES,
  parameter int MAX_SLOTS    = sscs_pkg::DEF_MAX_SLOTS,
  parameter int NUM_TYPES    = sscs_pkg::DEF_NUM_TYPES,
  parameter int RECORD_BITS  = sscs_pkg::DEF_RECORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sscs_pkg::ctrl_cmd_t               cmd_i,
  output sscs_pkg::ctrl_sts_t               sts_o,
  input  logic [sscs_pkg::OP_W-1:0]         operation_i,
  input  logic [sscs_pkg::TYPE_W-1:0]       component_type_i,
  input  logic [sscs_pkg::ENT_W-1:0]        entity_id_i,
  input  logic [sscs_pkg::ENT_W-1:0]        dense_index_i,
  input  logic [sscs_pkg::PAYLOAD_W-1:0]    payload_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sscs_pkg::STATUS_W-1:0]     status_o,
  output logic                              present_o,
  output logic [sscs_pkg::SLOT_OUT_W-1:0]   slot_o,
  output logic [sscs_pkg::ENT_W-1:0]        owner_id_o,
  output logic [sscs_pkg::PAYLOAD_W-1:0]    record_o,
  output logic [sscs_pkg::COUNT_W-1:0]      live_count_o
);
  import sscs_pkg::*;

  localparam int SLOT_W   = $clog2(MAX_SLOTS);
  localparam int OWN_W    = $clog2(MAX_ENTITIES);
  localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int TIDX_W   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int SP_DEPTH = NUM_TYPES * MAX_ENTITIES;
  localparam int DN_DEPTH = NUM_TYPES * MAX_SLOTS;
  localparam int SP_AW    = $clog2(SP_DEPTH);
  localparam int DN_AW    = $clog2(DN_DEPTH);
  localparam int SP_W     = SLOT_W + 1;
  localparam int DN_W     = OWN_W + RECORD_BITS;

  // Latched request
  op_e                     op_q;
  logic [TYPE_W-1:0]       ty_q;
  logic [ENT_W-1:0]        ent_q;
  logic [ENT_W-1:0]        di_q;
  logic [RECORD_BITS-1:0]  pay_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_e'(operation_i);
      ty_q  <= component_type_i;
      ent_q <= entity_id_i;
      di_q  <= dense_index_i;
      pay_q <= payload_i[RECORD_BITS-1:0];
    end
  end

  // Per-type live counts
  logic [CNT_W-1:0] cnt_q [NUM_TYPES];
  logic [31:0]      ty_ext;
  logic [TIDX_W-1:0] ty_idx;
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_last;

  assign ty_ext   = 32'(ty_q);
  assign ty_idx   = ty_ext[TIDX_W-1:0];
  assign cnt_cur  = cnt_q[ty_idx];
  assign cnt_last = cnt_cur - CNT_W'(1);

  // Sparse table: {valid, slot}
  logic             sp_we;
  logic [SP_AW-1:0] sp_waddr;
  logic [SP_W-1:0]  sp_wdata;
  logic [SP_AW-1:0] sp_raddr;
  logic [SP_W-1:0]  sp_rdata;

  // Dense array: {owner, record}
  logic             dn_we;
  logic [DN_AW-1:0] dn_waddr;
  logic [DN_W-1:0]  dn_wdata;
  logic [DN_AW-1:0] dn_raddr;
  logic [DN_W-1:0]  dn_rdata;

  sscs_ram #(.WIDTH(SP_W), .DEPTH(SP_DEPTH)) u_sparse (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (sp_waddr),
    .wdata_i (sp_wdata),
    .raddr_i (sp_raddr),
    .rdata_o (sp_rdata)
  );

  sscs_ram #(.WIDTH(DN_W), .DEPTH(DN_DEPTH)) u_dense (
    .clk_i   (clk_i),
    .we_i    (dn_we),
    .waddr_i (dn_waddr),
    .wdata_i (dn_wdata),
    .raddr_i (dn_raddr),
    .rdata_o (dn_rdata)
  );

  // Sparse lookup issued straight from the ports in the accept cycle
  assign sp_raddr = SP_AW'(32'(component_type_i) * MAX_ENTITIES + 32'(entity_id_i));

  // Sparse entry captured when it returns
  logic              sp_valid_q;
  logic [SLOT_W-1:0] sp_slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.dread) begin
      sp_valid_q <= sp_rdata[SP_W-1];
      sp_slot_q  <= sp_rdata[SLOT_W-1:0];
    end
  end

  // Dense read: read slot, last slot on remove, else the mapped slot
  logic [31:0] dn_slot;
  always_comb begin
    case (op_q)
      OP_READ:   dn_slot = 32'(di_q);
      OP_REMOVE: dn_slot = 32'(cnt_last);
      default:   dn_slot = 32'(sp_rdata[SLOT_W-1:0]);
    endcase
  end
  assign dn_raddr = DN_AW'(32'(ty_q) * MAX_SLOTS + dn_slot);

  // Operation decode
  logic ty_bad, ent_bad, rd_empty, full;
  logic add_upd, add_new, rem_ok, swap;
  logic [OWN_W-1:0]       own_r;
  logic [RECORD_BITS-1:0] rec_r;

  assign own_r    = dn_rdata[DN_W-1:RECORD_BITS];
  assign rec_r    = dn_rdata[RECORD_BITS-1:0];
  assign ty_bad   = ty_ext >= 32'(NUM_TYPES);
  assign ent_bad  = 32'(ent_q) >= 32'(MAX_ENTITIES);
  assign rd_empty = (32'(di_q) >= 32'(cnt_cur)) || (32'(di_q) >= 32'(MAX_SLOTS));
  assign full     = 32'(cnt_cur) >= 32'(MAX_SLOTS);
  assign add_upd  = (op_q == OP_ADD) && !ty_bad && !ent_bad && sp_valid_q;
  assign add_new  = (op_q == OP_ADD) && !ty_bad && !ent_bad && !sp_valid_q && !full;
  assign rem_ok   = (op_q == OP_REMOVE) && !ty_bad && !ent_bad && sp_valid_q;
  assign swap     = rem_ok && (32'(sp_slot_q) != 32'(cnt_last));

  // Entity whose record moves on a swap remove
  logic [OWN_W-1:0] mover_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      mover_q <= own_r;
    end
  end

  // Clear sweep over the sparse table after reset
  logic [SP_AW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + SP_AW'(1);
    end
  end
  assign sts_o.clr_done = (32'(clr_q) == 32'(SP_DEPTH - 1));

  // Sparse write port
  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = SP_AW'(32'(ty_q) * MAX_ENTITIES + 32'(ent_q));
    sp_wdata = '0;
    if (cmd_i.clear) begin
      sp_we    = 1'b1;
      sp_waddr = clr_q;
    end else if (cmd_i.exec) begin
      sp_we    = add_new || rem_ok;
      sp_wdata = add_new ? {1'b1, cnt_cur[SLOT_W-1:0]} : '0;
    end else if (cmd_i.fix) begin
      sp_we    = 1'b1;
      sp_waddr = SP_AW'(32'(ty_q) * MAX_ENTITIES + 32'(mover_q));
      sp_wdata = {1'b1, sp_slot_q};
    end
  end

  // Dense write port
  always_comb begin
    dn_we    = cmd_i.exec && (add_upd || add_new || swap);
    dn_waddr = DN_AW'(32'(ty_q) * MAX_SLOTS + 32'(sp_slot_q));
    dn_wdata = dn_rdata;
    if (add_upd) begin
      dn_wdata = {own_r, pay_q};
    end else if (add_new) begin
      dn_waddr = DN_AW'(32'(ty_q) * MAX_SLOTS + 32'(cnt_cur));
      dn_wdata = {OWN_W'(32'(ent_q)), pay_q};
    end
  end

  assign sts_o.need_fix = swap;

  // Count update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (add_new) begin
        cnt_q[ty_idx] <= cnt_cur + CNT_W'(1);
      end else if (rem_ok) begin
        cnt_q[ty_idx] <= cnt_last;
      end
    end
  end

  // Result forming
  logic [STATUS_W-1:0]   r_status;
  logic                  r_present;
  logic [SLOT_OUT_W-1:0] r_slot;
  logic [ENT_W-1:0]      r_owner;
  logic [PAYLOAD_W-1:0]  r_record;
  logic [COUNT_W-1:0]    r_count;

  always_comb begin
    r_status  = STS_OK;
    r_present = 1'b0;
    r_slot    = '0;
    r_owner   = '0;
    r_record  = '0;
    r_count   = COUNT_W'(32'(cnt_cur));
    if (ty_bad) begin
      r_status = STS_REJECT;
      r_count  = '0;
    end else if (op_q == OP_READ) begin
      r_slot = SLOT_OUT_W'(32'(di_q));
      if (rd_empty) begin
        r_status = STS_ABSENT;
      end else begin
        r_present = 1'b1;
        r_owner   = ENT_W'(32'(own_r));
        r_record  = PAYLOAD_W'(rec_r);
      end
    end else if (ent_bad) begin
      r_status = (op_q == OP_ADD) ? STS_REJECT : STS_ABSENT;
    end else if (op_q == OP_ADD) begin
      if (add_upd) begin
        r_present = 1'b1;
        r_slot    = SLOT_OUT_W'(32'(sp_slot_q));
        r_owner   = ENT_W'(32'(own_r));
      end else if (full) begin
        r_status = STS_REJECT;
      end else begin
        r_present = 1'b1;
        r_slot    = SLOT_OUT_W'(32'(cnt_cur));
        r_owner   = ent_q;
        r_count   = COUNT_W'(32'(cnt_cur) + 32'd1);
      end
    end else if (!sp_valid_q) begin
      r_status = STS_ABSENT;
    end else if (op_q == OP_LOOKUP) begin
      r_present = 1'b1;
      r_slot    = SLOT_OUT_W'(32'(sp_slot_q));
      r_owner   = ENT_W'(32'(own_r));
      r_record  = PAYLOAD_W'(rec_r);
    end else begin
      // remove: owner now in the freed slot is the last record's owner
      r_slot  = SLOT_OUT_W'(32'(sp_slot_q));
      r_owner = ENT_W'(32'(own_r));
      r_count = COUNT_W'(32'(cnt_last));
    end
  end

  // Result holding register
  logic [STATUS_W-1:0]   res_status_q;
  logic                  res_present_q;
  logic [SLOT_OUT_W-1:0] res_slot_q;
  logic [ENT_W-1:0]      res_owner_q;
  logic [PAYLOAD_W-1:0]  res_record_q;
  logic [COUNT_W-1:0]    res_count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_q  <= r_status;
      res_present_q <= r_present;
      res_slot_q    <= r_slot;
      res_owner_q   <= r_owner;
      res_record_q  <= r_record;
      res_count_q   <= r_count;
    end
  end

  // Output register
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic                  out_present_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic [ENT_W-1:0]      out_owner_q;
  logic [PAYLOAD_W-1:0]  out_record_q;
  logic [COUNT_W-1:0]    out_count_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_status_q  <= res_status_q;
      out_present_q <= res_present_q;
      out_slot_q    <= res_slot_q;
      out_owner_q   <= res_owner_q;
      out_record_q  <= res_record_q;
      out_count_q   <= res_count_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign present_o    = out_present_q;
  assign slot_o       = out_slot_q;
  assign owner_id_o   = out_owner_q;
  assign record_o     = out_record_q;
  assign live_count_o = out_count_q;

endmodule

### hw/rtl/sparse_set_component_store_unit.sv
// Channel   Handshake                   Beat contents
// input     in_valid_i / in_ready_o     operation, component_type, entity_id,
//                                       dense_index, payload
// output    out_valid_o / out_ready_i   status, present, slot, owner_id,
//                                       record, live_count
//
// Each item steps through accept, sparse read, dense read and update, and result
// load, in that order; the next item is taken only after that load. A remove that
// moves a record adds a repoint step: the sparse table has one write port and
// that remove writes it twice (freed entity, then the moved entity).
// After reset the sparse table is swept to absent, one entry a cycle, over all
// NUM_TYPES * MAX_ENTITIES entries (1024 at defaults); in_ready_o is low.
// A finished result sits in the output register; the next item is taken
// while it waits and holds in its last step until the register frees.
module sparse_set_component_store_unit #(
  parameter int MAX_ENTITIES = sscs_pkg::DEF_MAX_ENTITIES,
  parameter int MAX_SLOTS    = sscs_pkg::DEF_MAX_SLOTS,
  parameter int NUM_TYPES    = sscs_pkg::DEF_NUM_TYPES,
  parameter int RECORD_BITS  = sscs_pkg::DEF_RECORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sscs_pkg::OP_W-1:0]         operation_i,
  input  logic [sscs_pkg::TYPE_W-1:0]       component_type_i,
  input  logic [sscs_pkg::ENT_W-1:0]        entity_id_i,
  input  logic [sscs_pkg::ENT_W-1:0]        dense_index_i,
  input  logic [sscs_pkg::PAYLOAD_W-1:0]    payload_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sscs_pkg::STATUS_W-1:0]     status_o,
  output logic                              present_o,
  output logic [sscs_pkg::SLOT_OUT_W-1:0]   slot_o,
  output logic [sscs_pkg::ENT_W-1:0]        owner_id_o,
  output logic [sscs_pkg::PAYLOAD_W-1:0]    record_o,
  output logic [sscs_pkg::COUNT_W-1:0]      live_count_o
);
  import sscs_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer
  sscs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Tables, counts and result path
  sscs_datapath #(
    .MAX_ENTITIES (MAX_ENTITIES),
    .MAX_SLOTS    (MAX_SLOTS),
    .NUM_TYPES    (NUM_TYPES),
    .RECORD_BITS  (RECORD_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .component_type_i (component_type_i),
    .entity_id_i      (entity_id_i),
    .dense_index_i    (dense_index_i),
    .payload_i        (payload_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .present_o        (present_o),
    .slot_o           (slot_o),
    .owner_id_o       (owner_id_o),
    .record_o         (record_o),
    .live_count_o     (live_count_o)
  );

endmodule
